// ===== hdl/dfa_tsm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dfa_tsm_pkg;

  // Automaton geometry
  localparam int NUM_STATES = 256;
  localparam int STATE_W    = 8;
  localparam int SYM_W      = 8;
  localparam int TRANS_AW   = STATE_W + SYM_W;
  localparam int TRANS_DEPTH = NUM_STATES * (1 << SYM_W);

  // Text offsets
  localparam int POS_W    = 16;
  localparam longint MAX_TEXT = 65535;
  localparam logic [POS_W-1:0] POS_CAP =
    POS_W'((MAX_TEXT < 65535) ? MAX_TEXT : 65535);

  // Output buffer
  localparam int BUF_DEPTH = 2;
  localparam int BUF_PW    = $clog2(BUF_DEPTH);
  localparam int BUF_CW    = $clog2(BUF_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    ACT_TRANS  = 2'd0,
    ACT_ACCEPT = 2'd1,
    ACT_TEXT   = 2'd2,
    ACT_END    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_STATE = 1'b0,
    CFG_FIND_ALL    = 1'b1
  } cfg_reg_t;

  // One transition table entry
  typedef struct packed {
    logic               present;
    logic [STATE_W-1:0] target;
  } trans_t;

  // Result item
  typedef struct packed {
    logic             result_kind;
    logic [POS_W-1:0] span_start;
    logic [POS_W-1:0] span_length;
    logic             verdict;
    logic             position_overflow;
  } result_t;

  // Table write request
  typedef struct packed {
    logic               trans_we;
    logic               acc_we;
    logic [STATE_W-1:0] state;
    logic [SYM_W-1:0]   sym;
    trans_t             trans;
    logic               acc;
  } tbl_wr_t;

  // Table read request
  typedef struct packed {
    logic               en;
    logic [STATE_W-1:0] cur;
    logic [STATE_W-1:0] start;
    logic [SYM_W-1:0]   sym;
  } tbl_rq_t;

  // Table read data, registered from the request
  typedef struct packed {
    trans_t trans_cur;
    trans_t trans_start;
    logic   acc_cur;
  } tbl_rd_t;

  // Output buffer status
  typedef struct packed {
    logic [BUF_CW-1:0] level;
    logic              pop;
  } buf_stat_t;

  function automatic logic state_ok(input logic [STATE_W-1:0] s);
    return {1'b0, s} < (STATE_W + 1)'(NUM_STATES);
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dfa_tsm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface dfa_tsm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          action;
  logic [dfa_tsm_pkg::STATE_W-1:0]     state_index;
  logic [dfa_tsm_pkg::SYM_W-1:0]       symbol;
  logic [dfa_tsm_pkg::STATE_W-1:0]     next_state;
  logic                                edge_present;
  logic                                accepting;

  modport source (output valid, action, state_index, symbol, next_state, edge_present,
                  accepting, input ready);
  modport sink (input valid, action, state_index, symbol, next_state, edge_present,
                accepting, output ready);
endinterface

// Result item channel
interface dfa_tsm_out_if;
  logic                            valid;
  logic                            ready;
  logic                            result_kind;
  logic [dfa_tsm_pkg::POS_W-1:0]   span_start;
  logic [dfa_tsm_pkg::POS_W-1:0]   span_length;
  logic                            verdict;
  logic                            position_overflow;

  modport source (output valid, result_kind, span_start, span_length, verdict,
                  position_overflow, input ready);
  modport sink (input valid, result_kind, span_start, span_length, verdict,
                position_overflow, output ready);
endinterface

// Configuration write channel
interface dfa_tsm_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [dfa_tsm_pkg::CFG_IDX_W-1:0]    index;
  logic [dfa_tsm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/dfa_table_stream_matcher_unit.sv =====
// Table-driven automaton matcher over a byte stream.
// in_ch carries load items (one transition entry or one accepting flag) and text
// items (a text byte, or end of text). out_ch carries at most one result per item:
// a span found mid-text (find-all mode) or the end-of-text verdict / final span.
// cfg_ch writes start_state (index 0) and find_all_mode (index 1); always ready.
// Throughput: one item per cycle while in_ch.ready is high. The limit is the
// transition loop: the table read data feeds the next-state select, which forms the
// next read address. A result passes the registered table read, then next-state and
// result logic into the output buffer, from which out_ch presents it.
// Reset: the transition table and accepting flags are swept to zero, one entry
// per cycle over NUM_STATES * 256 = 65536 entries; in_ch.ready stays low meanwhile.
// Stall: results wait in a two-entry buffer; after the sweep, input is taken while
// buffer and result stage have room, so in_ch.ready drops only when out_ch stalls.
`timescale 1ns / 1ps
`default_nettype none

module dfa_table_stream_matcher_unit (
  input  logic           clk,
  input  logic           rst_n,
  dfa_tsm_in_if.sink     in_ch,
  dfa_tsm_out_if.source  out_ch,
  dfa_tsm_cfg_if.sink    cfg_ch
);

  localparam int SW = dfa_tsm_pkg::STATE_W;
  localparam int PW = dfa_tsm_pkg::POS_W;

  logic                  in_acc;
  logic                  cfg_acc;
  dfa_tsm_pkg::action_t  in_act;

  // Configuration
  logic [SW-1:0] start_r;
  logic          mode_r;

  // Text bookkeeping
  logic [SW-1:0] cur_r, cur_nxt;
  logic [PW-1:0] origin_r, origin_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          rej_r, rej_nxt;
  logic          sat_r, sat_nxt;

  // Result stage
  logic                 s2_valid_r;
  dfa_tsm_pkg::action_t s2_act_r;
  logic                 s2_cur_ok_r;
  logic                 s2_start_ok_r;
  logic                 s2_res;

  dfa_tsm_pkg::tbl_wr_t   tbl_wr;
  dfa_tsm_pkg::tbl_rq_t   tbl_rq;
  dfa_tsm_pkg::tbl_rd_t   tbl_rd;
  logic                   tbl_busy;
  dfa_tsm_pkg::buf_stat_t buf_stat;
  dfa_tsm_pkg::result_t   res;
  logic                   res_push;
  logic [dfa_tsm_pkg::BUF_CW-1:0] occ;

  dfa_tsm_pkg::trans_t ta;
  dfa_tsm_pkg::trans_t tb;
  logic                acc_cur;
  logic [PW-1:0]       len_now;

  assign in_act  = dfa_tsm_pkg::action_t'(in_ch.action);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // Hold input while the table sweeps or no result slot is left
  assign s2_res = s2_valid_r && (s2_act_r == dfa_tsm_pkg::ACT_TEXT ||
                                 s2_act_r == dfa_tsm_pkg::ACT_END);
  assign occ = dfa_tsm_pkg::BUF_CW'(buf_stat.level
                                    + {{(dfa_tsm_pkg::BUF_CW-1){1'b0}}, s2_res}
                                    - {{(dfa_tsm_pkg::BUF_CW-1){1'b0}}, buf_stat.pop});
  assign in_ch.ready = !tbl_busy && (occ < dfa_tsm_pkg::BUF_CW'(dfa_tsm_pkg::BUF_DEPTH));

  // Load items write the table at acceptance
  always_comb begin
    tbl_wr.trans_we      = in_acc && in_act == dfa_tsm_pkg::ACT_TRANS &&
                           dfa_tsm_pkg::state_ok(in_ch.state_index);
    tbl_wr.acc_we        = in_acc && in_act == dfa_tsm_pkg::ACT_ACCEPT &&
                           dfa_tsm_pkg::state_ok(in_ch.state_index);
    tbl_wr.state         = in_ch.state_index;
    tbl_wr.sym           = in_ch.symbol;
    tbl_wr.trans.present = in_ch.edge_present;
    tbl_wr.trans.target  = in_ch.edge_present ? in_ch.next_state : '0;
    tbl_wr.acc           = in_ch.accepting;
  end

  // Read with the forwarded next state
  always_comb begin
    tbl_rq.en    = in_acc;
    tbl_rq.cur   = cur_nxt;
    tbl_rq.start = start_r;
    tbl_rq.sym   = in_ch.symbol;
  end

  dfa_tsm_table u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .wr   (tbl_wr),
    .rq   (tbl_rq),
    .rd   (tbl_rd),
    .busy (tbl_busy)
  );

  // Advance the result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    s2_act_r      <= in_act;
    s2_cur_ok_r   <= dfa_tsm_pkg::state_ok(cur_nxt);
    s2_start_ok_r <= dfa_tsm_pkg::state_ok(start_r);
  end

  // Drop table data of states beyond the table
  always_comb begin
    ta         = tbl_rd.trans_cur;
    ta.present = tbl_rd.trans_cur.present && s2_cur_ok_r;
    tb         = tbl_rd.trans_start;
    tb.present = tbl_rd.trans_start.present && s2_start_ok_r;
    acc_cur    = tbl_rd.acc_cur && s2_cur_ok_r;
    len_now    = (pos_r >= origin_r) ? PW'(pos_r - origin_r) : '0;
  end

  // Step the automaton and form the result
  always_comb begin
    cur_nxt    = cur_r;
    origin_nxt = origin_r;
    pos_nxt    = pos_r;
    rej_nxt    = rej_r;
    sat_nxt    = sat_r;
    res        = '0;
    res_push   = 1'b0;
    if (s2_valid_r) begin
      case (s2_act_r)
        dfa_tsm_pkg::ACT_TEXT: begin
          pos_nxt = (pos_r == dfa_tsm_pkg::POS_CAP) ? dfa_tsm_pkg::POS_CAP
                                                    : PW'(pos_r + 1'b1);
          sat_nxt = sat_r || (pos_r == dfa_tsm_pkg::POS_CAP);
          if (!mode_r) begin
            if (!rej_r) begin
              if (ta.present) begin
                cur_nxt = ta.target;
              end else begin
                rej_nxt = 1'b1;
              end
            end
          end else if (ta.present) begin
            cur_nxt = ta.target;
          end else begin
            if (acc_cur) begin
              res_push              = 1'b1;
              res.result_kind       = 1'b0;
              res.span_start        = origin_r;
              res.span_length       = len_now;
              res.verdict           = 1'b1;
              res.position_overflow = sat_nxt;
            end
            // retry the byte from the start state, skip it on a second miss
            if (tb.present) begin
              cur_nxt    = tb.target;
              origin_nxt = pos_r;
            end else begin
              cur_nxt    = start_r;
              origin_nxt = pos_nxt;
            end
          end
        end
        dfa_tsm_pkg::ACT_END: begin
          res_push              = 1'b1;
          res.result_kind       = 1'b1;
          res.position_overflow = sat_r;
          if (!mode_r) begin
            res.verdict = !rej_r && acc_cur;
          end else if (acc_cur) begin
            res.span_start  = origin_r;
            res.span_length = len_now;
            res.verdict     = 1'b1;
          end
          // rewind for the next text
          cur_nxt    = start_r;
          origin_nxt = '0;
          pos_nxt    = '0;
          rej_nxt    = 1'b0;
          sat_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end
    // Take a start write as the current state before the first byte of a text
    if (cfg_acc && dfa_tsm_pkg::cfg_reg_t'(cfg_ch.index) == dfa_tsm_pkg::CFG_START_STATE &&
        pos_nxt == '0 && !sat_nxt) begin
      cur_nxt = cfg_ch.data[SW-1:0];
    end
  end

  // Hold bookkeeping and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= '0;
      mode_r   <= 1'b0;
      cur_r    <= '0;
      origin_r <= '0;
      pos_r    <= '0;
      rej_r    <= 1'b0;
      sat_r    <= 1'b0;
    end else begin
      cur_r    <= cur_nxt;
      origin_r <= origin_nxt;
      pos_r    <= pos_nxt;
      rej_r    <= rej_nxt;
      sat_r    <= sat_nxt;
      if (cfg_acc) begin
        case (dfa_tsm_pkg::cfg_reg_t'(cfg_ch.index))
          dfa_tsm_pkg::CFG_START_STATE: begin
            start_r <= cfg_ch.data[SW-1:0];
          end
          dfa_tsm_pkg::CFG_FIND_ALL: begin
            mode_r <= cfg_ch.data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  dfa_tsm_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res),
    .stat     (buf_stat),
    .out_ch   (out_ch)
  );

  // Result stage plus buffer never exceed the buffer depth
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, buf_stat.level} + {{dfa_tsm_pkg::BUF_CW{1'b0}}, s2_res})
      <= (dfa_tsm_pkg::BUF_CW + 1)'(dfa_tsm_pkg::BUF_DEPTH))
    else $error("result stage overran the output buffer");

  // No item is taken during the table sweep
  a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_busy |-> !in_ch.ready)
    else $error("input ready during table sweep");

  // Saturation flag implies the position sits at its cap
  a_sat_cap: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> pos_r == dfa_tsm_pkg::POS_CAP)
    else $error("saturation flag without capped position");

  // End of text rewinds the bookkeeping
  a_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_act_r == dfa_tsm_pkg::ACT_END) |=>
      (pos_r == '0 && !rej_r && !sat_r && origin_r == '0))
    else $error("end of text did not rewind");

endmodule

`default_nettype wire

// ===== hdl/dfa_tsm_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfa_tsm_table (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dfa_tsm_pkg::tbl_wr_t wr,
  input  dfa_tsm_pkg::tbl_rq_t rq,
  output dfa_tsm_pkg::tbl_rd_t rd,
  output logic                 busy
);

  dfa_tsm_pkg::trans_t trans_mem [dfa_tsm_pkg::TRANS_DEPTH];
  logic                acc_mem   [dfa_tsm_pkg::NUM_STATES];

  logic                                clr_r;
  logic [dfa_tsm_pkg::TRANS_AW-1:0]    clr_addr_r;
  logic                                clr_acc;

  assign busy    = clr_r;
  assign clr_acc = {1'b0, clr_addr_r} < (dfa_tsm_pkg::TRANS_AW + 1)'(dfa_tsm_pkg::NUM_STATES);

  // Sweep every entry once after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == dfa_tsm_pkg::TRANS_AW'(dfa_tsm_pkg::TRANS_DEPTH - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Write port: clearing sweep or load item
  always_ff @(posedge clk) begin
    if (clr_r) begin
      trans_mem[clr_addr_r] <= '0;
      if (clr_acc) begin
        acc_mem[clr_addr_r[dfa_tsm_pkg::STATE_W-1:0]] <= 1'b0;
      end
    end else begin
      if (wr.trans_we) begin
        trans_mem[{wr.state, wr.sym}] <= wr.trans;
      end
      if (wr.acc_we) begin
        acc_mem[wr.state] <= wr.acc;
      end
    end
  end

  // Read ports: current state, start state, accepting flag
  always_ff @(posedge clk) begin
    if (rq.en) begin
      rd.trans_cur   <= trans_mem[{rq.cur, rq.sym}];
      rd.trans_start <= trans_mem[{rq.start, rq.sym}];
      rd.acc_cur     <= acc_mem[rq.cur];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dfa_tsm_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dfa_tsm_out_buf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  dfa_tsm_pkg::result_t   push_data,
  output dfa_tsm_pkg::buf_stat_t stat,
  dfa_tsm_out_if.source          out_ch
);

  dfa_tsm_pkg::result_t slot_r [dfa_tsm_pkg::BUF_DEPTH];

  logic [dfa_tsm_pkg::BUF_PW-1:0] wr_ptr_r;
  logic [dfa_tsm_pkg::BUF_PW-1:0] rd_ptr_r;
  logic [dfa_tsm_pkg::BUF_CW-1:0] cnt_r;
  logic                           pop;
  dfa_tsm_pkg::result_t           head;

  assign head = slot_r[rd_ptr_r];
  assign pop  = out_ch.valid && out_ch.ready;

  // Present the oldest item
  assign out_ch.valid             = cnt_r != '0;
  assign out_ch.result_kind       = head.result_kind;
  assign out_ch.span_start        = head.span_start;
  assign out_ch.span_length       = head.span_length;
  assign out_ch.verdict           = head.verdict;
  assign out_ch.position_overflow = head.position_overflow;

  assign stat.level = cnt_r;
  assign stat.pop   = pop;

  // Store pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= dfa_tsm_pkg::BUF_CW'(cnt_r + {{(dfa_tsm_pkg::BUF_CW-1){1'b0}}, push}
                                   - {{(dfa_tsm_pkg::BUF_CW-1){1'b0}}, pop});
    end
  end

endmodule

`default_nettype wire
